// ===== design/lome_pkg.sv =====
// Package for the limit order matching engine.
// Holds default sizes, codes, the controller state type and the command and status structs.
// No dependencies.
package lome_pkg;

  localparam int DEF_MAX_ORDERS = 32;
  localparam int DEF_PRICE_BITS = 16;
  localparam int DEF_QTY_BITS   = 24;
  localparam int DEF_ID_BITS    = 32;
  localparam int STAMP_BITS     = 64;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_CANCEL = 2'd1;
  localparam logic [1:0] MODE_MODIFY = 2'd2;
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  typedef enum logic [2:0] {
    KIND_TRADE     = 3'd0,
    KIND_ACCEPTED  = 3'd1,
    KIND_CANCELLED = 3'd2,
    KIND_NOTFOUND  = 3'd3,
    KIND_FULL      = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    SK_CLEAR,
    SK_FIND,
    SK_FREE,
    SK_BEST
  } scan_kind_t;

  typedef enum logic [2:0] {
    ST_RESET,
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_FIND,
    ST_FREE,
    ST_BEST,
    ST_WASK
  } state_t;

  typedef struct packed {
    logic       latch_input;
    logic       start_scan;
    scan_kind_t scan_kind;
    logic       wr_clear_found;
    logic       wr_new;
    logic       wr_bid;
    logic       wr_ask;
    logic       emit;
    kind_t      emit_kind;
    logic       emit_last;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic mode_add;
    logic mode_mod;
    logic found;
    logic free_ok;
    logic crossed;
    logic qty_nz;
  } ctl_stat_t;

endpackage

// ===== design/lome_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module lome_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/lome_ctrl.sv =====
// Controller state machine of the limit order matching engine.
// Depends on lome_pkg for the state type and the command and status structs.
module lome_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  lome_pkg::ctl_stat_t stat,
  output lome_pkg::ctl_cmd_t  cmd
);
  import lome_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RESET;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_RESET: state_nxt = ST_CLEAR;
      ST_CLEAR: if (stat.scan_done) state_nxt = ST_IDLE;
      ST_IDLE: if (start) state_nxt = ST_DISPATCH;
      ST_DISPATCH: state_nxt = stat.mode_add ? ST_FREE : ST_FIND;
      ST_FIND: begin
        if (stat.scan_done) begin
          state_nxt = (stat.found && stat.mode_mod) ? ST_FREE : ST_IDLE;
        end
      end
      ST_FREE: if (stat.scan_done) state_nxt = stat.free_ok ? ST_BEST : ST_IDLE;
      ST_BEST: if (stat.scan_done) state_nxt = stat.crossed ? ST_WASK : ST_IDLE;
      ST_WASK: state_nxt = ST_BEST;
      default: state_nxt = ST_RESET;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.scan_kind = SK_CLEAR;
    cmd.emit_kind = KIND_TRADE;
    busy = 1'b1;
    case (state_r)
      ST_RESET: begin
        cmd.start_scan = 1'b1;
        cmd.scan_kind = SK_CLEAR;
      end
      ST_CLEAR: ;
      ST_IDLE: begin
        busy = 1'b0;
        cmd.latch_input = start;
      end
      ST_DISPATCH: begin
        cmd.start_scan = 1'b1;
        cmd.scan_kind = stat.mode_add ? SK_FREE : SK_FIND;
      end
      ST_FIND: begin
        if (stat.scan_done) begin
          cmd.emit = 1'b1;
          if (stat.found) begin
            cmd.wr_clear_found = 1'b1;
            cmd.emit_kind = KIND_CANCELLED;
            cmd.emit_last = !stat.mode_mod;
            cmd.start_scan = stat.mode_mod;
            cmd.scan_kind = SK_FREE;
          end else begin
            cmd.emit_kind = KIND_NOTFOUND;
            cmd.emit_last = 1'b1;
          end
        end
      end
      ST_FREE: begin
        if (stat.scan_done) begin
          if (stat.free_ok) begin
            cmd.wr_new = 1'b1;
            cmd.start_scan = 1'b1;
            cmd.scan_kind = SK_BEST;
          end else begin
            cmd.emit = 1'b1;
            cmd.emit_kind = KIND_FULL;
            cmd.emit_last = 1'b1;
          end
        end
      end
      ST_BEST: begin
        if (stat.scan_done) begin
          if (stat.crossed) begin
            cmd.wr_bid = 1'b1;
            cmd.emit = stat.qty_nz;
            cmd.emit_kind = KIND_TRADE;
          end else begin
            cmd.emit = 1'b1;
            cmd.emit_kind = KIND_ACCEPTED;
            cmd.emit_last = 1'b1;
          end
        end
      end
      ST_WASK: begin
        cmd.wr_ask = 1'b1;
        cmd.start_scan = 1'b1;
        cmd.scan_kind = SK_BEST;
      end
      default: ;
    endcase
  end

endmodule

// ===== design/lome_dp.sv =====
// Datapath of the limit order matching engine: order table, scan unit and result registers.
// Depends on lome_pkg and lome_ram.
module lome_dp #(
  parameter int MAX_ORDERS = lome_pkg::DEF_MAX_ORDERS,
  parameter int PRICE_BITS = lome_pkg::DEF_PRICE_BITS,
  parameter int QTY_BITS   = lome_pkg::DEF_QTY_BITS,
  parameter int ID_BITS    = lome_pkg::DEF_ID_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lome_pkg::ctl_cmd_t    cmd,
  output lome_pkg::ctl_stat_t   stat,
  input  logic [1:0]            in_mode,
  input  logic [ID_BITS-1:0]    in_target_id,
  input  logic [PRICE_BITS-1:0] in_limit_price,
  input  logic [QTY_BITS-1:0]   in_order_quantity,
  input  logic                  in_order_side,
  output logic                  out_strobe,
  output logic [2:0]            out_result_kind,
  output logic [ID_BITS-1:0]    out_assigned_id,
  output logic [ID_BITS-1:0]    out_ask_order_id,
  output logic [ID_BITS-1:0]    out_bid_order_id,
  output logic [PRICE_BITS-1:0] out_trade_price,
  output logic [QTY_BITS-1:0]   out_trade_quantity,
  output logic                  out_last
);
  import lome_pkg::*;

  localparam int IDX_BITS  = $clog2(MAX_ORDERS);
  localparam int CNT_BITS  = $clog2(MAX_ORDERS + 1);
  localparam int PR_LO     = ID_BITS;
  localparam int QT_LO     = PR_LO + PRICE_BITS;
  localparam int SM_LO     = QT_LO + QTY_BITS;
  localparam int SD_POS    = SM_LO + STAMP_BITS;
  localparam int VL_POS    = SD_POS + 1;
  localparam int WORD_BITS = VL_POS + 1;

  logic [1:0]            mode_r;
  logic [ID_BITS-1:0]    tid_r;
  logic [PRICE_BITS-1:0] price_r;
  logic [QTY_BITS-1:0]   qty_r;
  logic                  side_r;

  logic [ID_BITS-1:0]    next_id_r, new_id_r;
  logic [STAMP_BITS-1:0] stamp_r;

  logic                  scanning_r, rv_r;
  scan_kind_t            kind_r;
  logic [CNT_BITS-1:0]   cnt_r;
  logic [IDX_BITS-1:0]   ridx_r;
  logic                  issuing;

  logic                  found_r;
  logic [IDX_BITS-1:0]   found_idx_r;
  logic [STAMP_BITS-1:0] found_stamp_r;
  logic                  free_ok_r;
  logic [IDX_BITS-1:0]   free_idx_r;

  logic                  bv_r, av_r;
  logic [IDX_BITS-1:0]   bidx_r, aidx_r;
  logic [ID_BITS-1:0]    bid_r, aid_r;
  logic [PRICE_BITS-1:0] bp_r, ap_r;
  logic [QTY_BITS-1:0]   bq_r, aq_r;
  logic [STAMP_BITS-1:0] bs_r, as_r;

  logic [WORD_BITS-1:0]  rdata, wdata;
  logic [IDX_BITS-1:0]   waddr;
  logic                  we;
  logic [ID_BITS-1:0]    rd_id;
  logic [PRICE_BITS-1:0] rd_price;
  logic [QTY_BITS-1:0]   rd_qty;
  logic [STAMP_BITS-1:0] rd_stamp;
  logic                  rd_side, rd_valid;

  logic [QTY_BITS-1:0]   q, bq_rem, aq_rem;
  logic [PRICE_BITS-1:0] tp;

  logic                  strobe_r, last_r;
  kind_t                 kind_out_r;
  logic [ID_BITS-1:0]    o_assigned_r, o_ask_r, o_bid_r;
  logic [PRICE_BITS-1:0] o_price_r;
  logic [QTY_BITS-1:0]   o_qty_r;

  assign rd_id    = rdata[PR_LO-1:0];
  assign rd_price = rdata[QT_LO-1:PR_LO];
  assign rd_qty   = rdata[SM_LO-1:QT_LO];
  assign rd_stamp = rdata[SD_POS-1:SM_LO];
  assign rd_side  = rdata[SD_POS];
  assign rd_valid = rdata[VL_POS];

  assign issuing = scanning_r && (cnt_r != CNT_BITS'(MAX_ORDERS));

  assign q      = (bq_r < aq_r) ? bq_r : aq_r;
  assign bq_rem = bq_r - q;
  assign aq_rem = aq_r - q;
  assign tp     = (bp_r > ap_r) ? bp_r : ap_r;

  always_comb begin
    we = 1'b0;
    waddr = cnt_r[IDX_BITS-1:0];
    wdata = '0;
    if (issuing && kind_r == SK_CLEAR) begin
      we = 1'b1;
    end else if (cmd.wr_clear_found) begin
      we = 1'b1;
      waddr = found_idx_r;
    end else if (cmd.wr_new) begin
      we = 1'b1;
      waddr = free_idx_r;
      wdata = {1'b1, side_r, stamp_r, qty_r, price_r, next_id_r};
    end else if (cmd.wr_bid) begin
      we = 1'b1;
      waddr = bidx_r;
      wdata = {bq_rem != '0, 1'b0, bs_r, bq_rem, bp_r, bid_r};
    end else if (cmd.wr_ask) begin
      we = 1'b1;
      waddr = aidx_r;
      wdata = {aq_rem != '0, 1'b1, as_r, aq_rem, ap_r, aid_r};
    end
  end

  lome_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MAX_ORDERS)
  ) u_book (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(cnt_r[IDX_BITS-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scanning_r <= 1'b0;
      rv_r       <= 1'b0;
      cnt_r      <= '0;
      kind_r     <= SK_CLEAR;
      next_id_r  <= '0;
      stamp_r    <= '0;
      strobe_r   <= 1'b0;
      last_r     <= 1'b0;
    end else begin
      rv_r <= issuing && (kind_r != SK_CLEAR);
      if (cmd.start_scan) begin
        scanning_r <= 1'b1;
        cnt_r      <= '0;
        kind_r     <= cmd.scan_kind;
      end else if (issuing) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!rv_r) begin
        scanning_r <= 1'b0;
      end
      if (cmd.wr_new) begin
        next_id_r <= next_id_r + 1'b1;
        stamp_r   <= stamp_r + 1'b1;
      end
      strobe_r <= cmd.emit;
      last_r   <= cmd.emit && cmd.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    ridx_r <= cnt_r[IDX_BITS-1:0];
    if (cmd.latch_input) begin
      mode_r  <= in_mode;
      tid_r   <= in_target_id;
      price_r <= in_limit_price;
      qty_r   <= in_order_quantity;
      side_r  <= in_order_side;
    end
    if (cmd.wr_new) begin
      new_id_r <= next_id_r;
    end
    if (cmd.start_scan) begin
      found_r   <= 1'b0;
      free_ok_r <= 1'b0;
      bv_r      <= 1'b0;
      av_r      <= 1'b0;
    end else if (rv_r && rd_valid) begin
      case (kind_r)
        SK_FIND: begin
          if (rd_id == tid_r && (!found_r || rd_stamp < found_stamp_r)) begin
            found_r       <= 1'b1;
            found_idx_r   <= ridx_r;
            found_stamp_r <= rd_stamp;
          end
        end
        SK_BEST: begin
          if (!rd_side) begin
            if (!bv_r || (rd_price == bp_r && rd_stamp < bs_r) || rd_price > bp_r) begin
              bv_r <= 1'b1; bidx_r <= ridx_r; bid_r <= rd_id;
              bp_r <= rd_price; bq_r <= rd_qty; bs_r <= rd_stamp;
            end
          end else begin
            if (!av_r || (rd_price == ap_r && rd_stamp < as_r) || rd_price < ap_r) begin
              av_r <= 1'b1; aidx_r <= ridx_r; aid_r <= rd_id;
              ap_r <= rd_price; aq_r <= rd_qty; as_r <= rd_stamp;
            end
          end
        end
        default: ;
      endcase
    end else if (rv_r && kind_r == SK_FREE && !free_ok_r) begin
      free_ok_r  <= 1'b1;
      free_idx_r <= ridx_r;
    end
    if (cmd.emit) begin
      kind_out_r   <= cmd.emit_kind;
      o_assigned_r <= '0;
      o_ask_r      <= '0;
      o_bid_r      <= '0;
      o_price_r    <= '0;
      o_qty_r      <= '0;
      case (cmd.emit_kind)
        KIND_TRADE: begin
          o_ask_r   <= aid_r;
          o_bid_r   <= bid_r;
          o_price_r <= tp;
          o_qty_r   <= q;
        end
        KIND_ACCEPTED: o_assigned_r <= new_id_r;
        KIND_CANCELLED, KIND_NOTFOUND: o_assigned_r <= tid_r;
        default: ;
      endcase
    end
  end

  always_comb begin
    stat.scan_done = scanning_r && !issuing && !rv_r;
    stat.mode_add  = (mode_r == MODE_ADD);
    stat.mode_mod  = (mode_r == MODE_MODIFY);
    stat.found     = found_r;
    stat.free_ok   = free_ok_r;
    stat.crossed   = bv_r && av_r && (bp_r >= ap_r);
    stat.qty_nz    = (q != '0);
  end

  assign out_strobe         = strobe_r;
  assign out_last           = last_r;
  assign out_result_kind    = kind_out_r;
  assign out_assigned_id    = o_assigned_r;
  assign out_ask_order_id   = o_ask_r;
  assign out_bid_order_id   = o_bid_r;
  assign out_trade_price    = o_price_r;
  assign out_trade_quantity = o_qty_r;

endmodule

// ===== design/limit_order_matching_engine.sv =====
// Limit order matching engine top level: controller plus datapath.
// Every table scan reads one book entry per cycle from the book RAM, which has separate
// write and read ports. One item is worked on at a time.
// After reset a clearing pass empties the book with busy high.
// Results appear one cycle each on out_strobe; the receiver cannot stall.
module limit_order_matching_engine #(
  parameter int MAX_ORDERS = lome_pkg::DEF_MAX_ORDERS,
  parameter int PRICE_BITS = lome_pkg::DEF_PRICE_BITS,
  parameter int QTY_BITS   = lome_pkg::DEF_QTY_BITS,
  parameter int ID_BITS    = lome_pkg::DEF_ID_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_mode,
  input  logic [ID_BITS-1:0]    in_target_id,
  input  logic [PRICE_BITS-1:0] in_limit_price,
  input  logic [QTY_BITS-1:0]   in_order_quantity,
  input  logic                  in_order_side,
  output logic                  out_strobe,
  output logic [2:0]            out_result_kind,
  output logic [ID_BITS-1:0]    out_assigned_id,
  output logic [ID_BITS-1:0]    out_ask_order_id,
  output logic [ID_BITS-1:0]    out_bid_order_id,
  output logic [PRICE_BITS-1:0] out_trade_price,
  output logic [QTY_BITS-1:0]   out_trade_quantity,
  output logic                  out_last
);
  import lome_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  lome_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .stat (stat),
    .cmd  (cmd)
  );

  lome_dp #(
    .MAX_ORDERS(MAX_ORDERS),
    .PRICE_BITS(PRICE_BITS),
    .QTY_BITS  (QTY_BITS),
    .ID_BITS   (ID_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_mode           (in_mode),
    .in_target_id      (in_target_id),
    .in_limit_price    (in_limit_price),
    .in_order_quantity (in_order_quantity),
    .in_order_side     (in_order_side),
    .out_strobe        (out_strobe),
    .out_result_kind   (out_result_kind),
    .out_assigned_id   (out_assigned_id),
    .out_ask_order_id  (out_ask_order_id),
    .out_bid_order_id  (out_bid_order_id),
    .out_trade_price   (out_trade_price),
    .out_trade_quantity(out_trade_quantity),
    .out_last          (out_last)
  );

endmodule

// ===== design/lome_checker.sv =====
// Port-level assertions for the limit order matching engine, bound to the top level.
// Depends on lome_pkg for the result codes.
module lome_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_strobe,
  input logic [2:0] out_result_kind,
  input logic       out_last
);
  import lome_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("Engine not busy after accepting a word.");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |=> !out_strobe)
    else $error("Result word directly after a final result.");

  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=> busy)
    else $error("Engine idle while results are still owed.");

  a_trade_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_result_kind == KIND_TRADE |-> !out_last)
    else $error("A trade was marked as the final result.");

  a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_result_kind == KIND_NOTFOUND || out_result_kind == KIND_FULL)
      |-> out_last)
    else $error("Rejection was not the final result.");

endmodule

bind limit_order_matching_engine lome_checker u_lome_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_strobe     (out_strobe),
  .out_result_kind(out_result_kind),
  .out_last       (out_last)
);

// ===== sim/tb.sv =====
// Testbench for limit_order_matching_engine: random and directed order flow with a scoreboard.
// The scoreboard keeps its own copy of the order book and predicts every result word.
// Depends on lome_pkg and the engine RTL.
module tb;
  import lome_pkg::*;

  localparam int NORD = DEF_MAX_ORDERS;
  localparam int PW   = DEF_PRICE_BITS;
  localparam int QW   = DEF_QTY_BITS;
  localparam int IW   = DEF_ID_BITS;

  typedef struct {
    kind_t         kind;
    logic [IW-1:0] id;
    logic [IW-1:0] ask;
    logic [IW-1:0] bid;
    logic [PW-1:0] price;
    logic [QW-1:0] qty;
    logic          last;
  } fill_word_t;

  class book_scoreboard;
    bit            live [NORD];
    logic [IW-1:0] oid [NORD];
    logic [PW-1:0] px [NORD];
    logic [QW-1:0] qty [NORD];
    bit            sd [NORD];
    longint unsigned stamp [NORD];
    logic [IW-1:0] next_id = '0;
    longint unsigned arrivals = 0;
    fill_word_t    pending [$];
    fill_word_t    awaited [$];
    int            errors = 0;
    int            orders = 0;
    int            trades = 0;
    int            fulls = 0;

    function void emit(kind_t k, logic [IW-1:0] i, logic [IW-1:0] a, logic [IW-1:0] b,
                       logic [PW-1:0] p, logic [QW-1:0] q);
      fill_word_t w;
      w.kind = k; w.id = i; w.ask = a; w.bid = b; w.price = p; w.qty = q; w.last = 1'b0;
      pending = {pending, w};
    endfunction

    function int best_of(bit s);
      int b;
      b = -1;
      for (int i = 0; i < NORD; i++) begin
        if (!live[i] || sd[i] != s) continue;
        if (b < 0) b = i;
        else if (px[i] == px[b]) begin
          if (stamp[i] < stamp[b]) b = i;
        end else if (s == 1'b0 ? px[i] > px[b] : px[i] < px[b]) b = i;
      end
      return b;
    endfunction

    function void cross_book();
      int b;
      int a;
      logic [QW-1:0] q;
      forever begin
        b = best_of(1'b0);
        a = best_of(1'b1);
        if (b < 0 || a < 0) return;
        if (px[b] < px[a]) return;
        q = qty[b] < qty[a] ? qty[b] : qty[a];
        if (q != 0) begin
          qty[b] -= q;
          qty[a] -= q;
          emit(KIND_TRADE, '0, oid[a], oid[b], px[b] > px[a] ? px[b] : px[a], q);
          trades++;
        end
        if (qty[b] == 0) live[b] = 1'b0;
        if (qty[a] == 0) live[a] = 1'b0;
      end
    endfunction

    function void rest_order(logic [PW-1:0] p, logic [QW-1:0] q, bit s);
      int slot;
      logic [IW-1:0] i;
      slot = -1;
      for (int k = 0; k < NORD; k++) if (!live[k] && slot < 0) slot = k;
      if (slot < 0) begin
        emit(KIND_FULL, '0, '0, '0, '0, '0);
        fulls++;
        return;
      end
      i = next_id;
      live[slot] = 1'b1; oid[slot] = i; px[slot] = p; qty[slot] = q; sd[slot] = s;
      stamp[slot] = arrivals++;
      next_id++;
      cross_book();
      emit(KIND_ACCEPTED, i, '0, '0, '0, '0);
    endfunction

    function void note_order(logic [1:0] m, logic [IW-1:0] t, logic [PW-1:0] p,
                             logic [QW-1:0] q, bit s);
      int f;
      orders++;
      if (m == MODE_ADD) rest_order(p, q, s);
      else begin
        f = -1;
        for (int k = 0; k < NORD; k++)
          if (live[k] && oid[k] == t && (f < 0 || stamp[k] < stamp[f])) f = k;
        if (f < 0) emit(KIND_NOTFOUND, t, '0, '0, '0, '0);
        else begin
          live[f] = 1'b0;
          emit(KIND_CANCELLED, t, '0, '0, '0, '0);
          if (m == MODE_MODIFY) rest_order(p, q, s);
        end
      end
      pending[$].last = 1'b1;
      foreach (pending[k]) awaited = {awaited, pending[k]};
      pending.delete();
    endfunction

    function void check_result(logic [2:0] k, logic [IW-1:0] i, logic [IW-1:0] a,
                               logic [IW-1:0] b, logic [PW-1:0] p, logic [QW-1:0] q,
                               logic l);
      fill_word_t w;
      if (awaited.size() == 0) begin
        $error("unexpected result word, kind %0d", k);
        errors++;
        return;
      end
      w = awaited[0];
      awaited.delete(0);
      if (k !== w.kind) begin
        $error("result_kind: expected %0d, got %0d", w.kind, k); errors++;
      end
      if (i !== w.id) begin
        $error("assigned_id: expected %0h, got %0h", w.id, i); errors++;
      end
      if (a !== w.ask) begin
        $error("ask_order_id: expected %0h, got %0h", w.ask, a); errors++;
      end
      if (b !== w.bid) begin
        $error("bid_order_id: expected %0h, got %0h", w.bid, b); errors++;
      end
      if (p !== w.price) begin
        $error("trade_price: expected %0h, got %0h", w.price, p); errors++;
      end
      if (q !== w.qty) begin
        $error("trade_quantity: expected %0h, got %0h", w.qty, q); errors++;
      end
      if (l !== w.last) begin
        $error("last: expected %0b, got %0b", w.last, l); errors++;
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  logic [1:0]    in_mode = MODE_ADD;
  logic [IW-1:0] in_target_id = '0;
  logic [PW-1:0] in_limit_price = '0;
  logic [QW-1:0] in_order_quantity = '0;
  logic          in_order_side = 1'b0;
  logic          out_strobe;
  logic [2:0]    out_result_kind;
  logic [IW-1:0] out_assigned_id;
  logic [IW-1:0] out_ask_order_id;
  logic [IW-1:0] out_bid_order_id;
  logic [PW-1:0] out_trade_price;
  logic [QW-1:0] out_trade_quantity;
  logic          out_last;

  book_scoreboard sb = new();
  bit             no_gaps = 1'b0;

  limit_order_matching_engine dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_target_id(in_target_id), .in_limit_price(in_limit_price),
    .in_order_quantity(in_order_quantity), .in_order_side(in_order_side),
    .out_strobe(out_strobe), .out_result_kind(out_result_kind),
    .out_assigned_id(out_assigned_id), .out_ask_order_id(out_ask_order_id),
    .out_bid_order_id(out_bid_order_id), .out_trade_price(out_trade_price),
    .out_trade_quantity(out_trade_quantity), .out_last(out_last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy)
        sb.note_order(in_mode, in_target_id, in_limit_price, in_order_quantity, in_order_side);
      if (out_strobe)
        sb.check_result(out_result_kind, out_assigned_id, out_ask_order_id, out_bid_order_id,
                        out_trade_price, out_trade_quantity, out_last);
    end
  end

  task automatic send_word(logic [1:0] m, logic [IW-1:0] t, logic [PW-1:0] p,
                           logic [QW-1:0] q, bit s);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    gap = no_gaps ? 0 : (r < 55 ? 0 : (r < 90 ? $urandom_range(1, 3) : $urandom_range(8, 40)));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= m;
    in_target_id <= t;
    in_limit_price <= p;
    in_order_quantity <= q;
    in_order_side <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic random_word();
    int r;
    logic [IW-1:0] t;
    logic [PW-1:0] p;
    logic [QW-1:0] q;
    r = $urandom_range(0, 99);
    t = sb.next_id - IW'($urandom_range(1, 40));
    if ($urandom_range(0, 9) == 0) t = IW'($urandom);
    p = PW'(16'd1000 + $urandom_range(0, 40) - 20);
    if ($urandom_range(0, 19) == 0) p = PW'($urandom);
    q = $urandom_range(0, 9) == 0 ? QW'($urandom) : QW'($urandom_range(1, 200));
    if ($urandom_range(0, 29) == 0) q = '0;
    if (r < 62) send_word(MODE_ADD, IW'($urandom), p, q, 1'($urandom_range(0, 1)));
    else if (r < 80)
      send_word(MODE_CANCEL, t, PW'($urandom), QW'($urandom), 1'($urandom_range(0, 1)));
    else if (r < 96) send_word(MODE_MODIFY, t, p, q, 1'($urandom_range(0, 1)));
    else send_word(MODE_SPARE, t, PW'($urandom), QW'($urandom), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int guard;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(MODE_ADD, '0, 16'd100, {QW{1'b1}}, 1'b0);
    send_word(MODE_ADD, '1, {PW{1'b1}}, '0, 1'b1);
    send_word(MODE_ADD, '0, '0, 24'd5, 1'b1);
    send_word(MODE_CANCEL, 32'd1, '0, '0, 1'b0);
    send_word(MODE_CANCEL, '1, '1, '1, 1'b1);
    send_word(MODE_SPARE, 32'd0, '0, '0, 1'b0);
    send_word(MODE_MODIFY, 32'd12345, 16'd5, 24'd5, 1'b0);
    send_word(MODE_ADD, '0, 16'd50, 24'd10, 1'b0);
    send_word(MODE_MODIFY, sb.next_id - 1, 16'd40, 24'd3, 1'b1);
    send_word(MODE_ADD, '0, 16'd200, '0, 1'b1);
    send_word(MODE_ADD, '0, 16'd300, 24'd7, 1'b0);
    no_gaps = 1'b1;
    repeat (NORD + 2) send_word(MODE_ADD, '0, 16'd1, 24'd3, 1'b0);
    no_gaps = 1'b0;
    send_word(MODE_ADD, '0, '0, {QW{1'b1}}, 1'b1);

    for (int k = 0; k < 480; k++) begin
      no_gaps = (k / 60) % 4 == 3;
      random_word();
    end
    start <= 1'b0;

    guard = 0;
    while (sb.awaited.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
    if (sb.awaited.size() != 0) begin
      $error("%0d result words never arrived", sb.awaited.size());
      sb.errors++;
    end
    $display("Sent %0d order words: %0d trades and %0d book-full rejects predicted.",
             sb.orders, sb.trades, sb.fulls);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("tb: failure");
    $finish;
  end
endmodule
